@@ rtl/core/wgs_pkg.sv @@
// Package for the waypoint guidance step: widths, command codes, CORDIC angle table.
// No dependencies.
`default_nettype none
package wgs_pkg;
	localparam int QueueDepthDef = 16;
	localparam int CoordBitsDef = 24;
	localparam int CordicStepsDef = 16;
	localparam int AngleTableLen = 24;
	localparam logic signed [33:0] CordicStart = 34'sd652032874;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_POSE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SPEED  = 2'd0,
		REG_RADIUS = 2'd1,
		REG_TURN   = 2'd2,
		REG_CLIMB  = 2'd3
	} reg_idx_t;

	function automatic logic [31:0] angle_at(input logic [4:0] i);
		logic [31:0] r;
		begin
			unique case (i)
				5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E;
				5'd2: r = 32'h09FB385B; 5'd3: r = 32'h051111D4;
				5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
				5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55;
				5'd8: r = 32'h0028BE53; 5'd9: r = 32'h00145F2F;
				5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
				5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
				5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
				5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
				default: r = 32'h0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/wgs_if.sv @@
// Valid/ready channel interfaces for command words and result words.
// No dependencies.
`default_nettype none
interface wgs_in_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [15:0] time_step;
	logic signed [23:0] coord_x;
	logic signed [23:0] coord_y;
	logic signed [23:0] coord_z;
	logic [15:0] heading_in;
	modport source(output valid, command, time_step, coord_x, coord_y, coord_z, heading_in,
		input ready);
	modport sink(input valid, command, time_step, coord_x, coord_y, coord_z, heading_in,
		output ready);
endinterface

interface wgs_out_if;
	logic valid;
	logic ready;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] pos_z;
	logic [15:0] heading_out;
	logic [4:0] waypoints_left;
	logic route_done;
	logic [15:0] landing_count;
	logic push_rejected;
	modport source(output valid, pos_x, pos_y, pos_z, heading_out, waypoints_left,
		route_done, landing_count, push_rejected, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, heading_out, waypoints_left,
		route_done, landing_count, push_rejected, output ready);
endinterface
`default_nettype wire

@@ rtl/core/wgs_cordic.sv @@
// Shared iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on wgs_pkg.
`default_nettype none
module wgs_cordic import wgs_pkg::*; #(
	parameter int CordicSteps = CordicStepsDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic vectoring,
	input  wire logic signed [35:0] x_in,
	input  wire logic signed [35:0] y_in,
	input  wire logic signed [33:0] z_in,
	output logic done,
	output logic signed [35:0] x_out,
	output logic signed [35:0] y_out,
	output logic signed [33:0] z_out
);
	localparam int IterW = $clog2(CordicSteps + 1);
	logic signed [35:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [IterW-1:0] iter_q;
	logic busy_q, vec_q, dir;
	logic signed [35:0] xs, ys;
	logic signed [33:0] ang;

	assign xs = x_q >>> iter_q;
	assign ys = y_q >>> iter_q;
	assign ang = $signed({2'b00, angle_at(5'(iter_q))});
	assign dir = vec_q ? (y_q > 0) : (z_q >= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			iter_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (iter_q == IterW'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_in;
			y_q <= y_in;
			z_q <= z_in;
			vec_q <= vectoring;
		end else if (busy_q) begin
			if (vec_q) begin
				if (dir) begin
					x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + ang;
				end else begin
					x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - ang;
				end
			end else begin
				if (dir) begin
					x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - ang;
				end else begin
					x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + ang;
				end
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;
endmodule
`default_nettype wire

@@ rtl/core/waypoint_guidance_step.sv @@
// Top level of the waypoint guidance step: sequencer, waypoint queue, datapath.
// Depends on wgs_pkg, wgs_if and wgs_cordic.
`default_nettype none
// One command word is taken at a time. For add, clear and set-pose words the
// result word is offered in the cycle after the command word is taken.
// A tick runs a vectoring CORDIC (atan2) and a rotation CORDIC (sin/cos), one
// after the other on the shared CORDIC unit, plus sequencer states for the queue
// read, reach test, CORDIC hand-over and multiplies. A tick that reaches its
// target, or runs with steering latched, skips the atan2. The result word sits
// in an output register until taken; the next command is accepted once it has gone.
module waypoint_guidance_step import wgs_pkg::*; #(
	parameter int QueueDepth = QueueDepthDef,
	parameter int CoordBits = CoordBitsDef,
	parameter int CordicSteps = CordicStepsDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	wgs_in_if.sink   in_ch,
	wgs_out_if.source out_ch,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [22:0] cfg_data
);
	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam logic signed [47:0] CoordHi = 48'sd2 ** (CoordBits - 1) - 48'sd1;
	localparam logic signed [47:0] CoordLo = -CoordHi - 48'sd1;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_LOAD  = 12'b000000000010,
		ST_DIFF  = 12'b000000000100,
		ST_SQ    = 12'b000000001000,
		ST_REACH = 12'b000000010000,
		ST_VSTRT = 12'b000000100000,
		ST_VWAIT = 12'b000001000000,
		ST_STEER = 12'b000010000000,
		ST_RSTRT = 12'b000100000000,
		ST_RWAIT = 12'b001000000000,
		ST_MOVE  = 12'b010000000000,
		ST_OUT   = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [15:0] speed_q;
	logic [22:0] radius_q, climb_q;
	logic [17:0] turn_q;

	logic [15:0] ts_q;

	logic signed [CoordBits-1:0] px_q, py_q, pz_q, tx_q, ty_q, tz_q;
	logic [15:0] head_q, land_q;
	logic [PtrW-1:0] fhead_q;
	logic [CntW-1:0] fcount_q;
	logic steer_off_q, route_q, rej_q, reached_q;

	logic [3*CoordBits-1:0] mem [QueueDepth];
	logic [3*CoordBits-1:0] rd_q;

	logic signed [CoordBits:0] dx_q, dy_q, dz_q;
	logic [CoordBits:0] adx, ady, adz;
	logic [2*CoordBits+3:0] sum_q;
	logic [47:0] r2_q;
	logic big_q;
	logic [17:0] rot_q;
	logic [22:0] climb_amt_q;
	logic [27:0] dist_q;
	logic signed [63:0] mvx_q, mvy_q;

	logic cd_start, cd_vec, cd_done;
	logic signed [35:0] cd_xi, cd_yi, cd_xo, cd_yo;
	logic signed [33:0] cd_zi, cd_zo;
	logic flip_q;

	function automatic logic signed [CoordBits-1:0] clampc(input logic signed [47:0] v);
		logic signed [CoordBits-1:0] r;
		begin
			if (v > CoordHi) r = CoordHi[CoordBits-1:0];
			else if (v < CoordLo) r = CoordLo[CoordBits-1:0];
			else r = v[CoordBits-1:0];
			return r;
		end
	endfunction

	assign adx = dx_q[CoordBits] ? (CoordBits+1)'(0) - dx_q : dx_q;
	assign ady = dy_q[CoordBits] ? (CoordBits+1)'(0) - dy_q : dy_q;
	assign adz = dz_q[CoordBits] ? (CoordBits+1)'(0) - dz_q : dz_q;

	wgs_cordic #(.CordicSteps(CordicSteps)) u_cordic (
		.clk, .arst_n, .start(cd_start), .vectoring(cd_vec),
		.x_in(cd_xi), .y_in(cd_yi), .z_in(cd_zi),
		.done(cd_done), .x_out(cd_xo), .y_out(cd_yo), .z_out(cd_zo)
	);

	logic [31:0] rot_ang;
	logic rflip;
	assign rot_ang = {head_q, 16'h0000};
	assign rflip = (32'(rot_ang - 32'h40000000) < 32'h80000000);
	assign cd_start = (state_q == ST_VSTRT) || (state_q == ST_RSTRT);
	assign cd_vec = (state_q == ST_VSTRT);
	always_comb begin
		if (state_q == ST_VSTRT) begin
			cd_xi = dx_q[CoordBits] ? 36'(-dx_q) : 36'(dx_q);
			cd_yi = dx_q[CoordBits] ? 36'(-dy_q) : 36'(dy_q);
			cd_zi = dx_q[CoordBits] ? 34'sh080000000 : 34'sd0;
		end else begin
			cd_xi = 36'(CordicStart);
			cd_yi = '0;
			cd_zi = rflip ? 34'($signed(32'(rot_ang - 32'h80000000)))
				: 34'($signed(rot_ang));
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.pos_x = 24'(px_q);
	assign out_ch.pos_y = 24'(py_q);
	assign out_ch.pos_z = 24'(pz_q);
	assign out_ch.heading_out = head_q;
	assign out_ch.waypoints_left = 5'(fcount_q);
	assign out_ch.route_done = route_q;
	assign out_ch.landing_count = land_q;
	assign out_ch.push_rejected = rej_q;

	logic [PtrW:0] wr_sum;
	logic [PtrW-1:0] wr_idx;
	assign wr_sum = {1'b0, fhead_q} + (PtrW+1)'(fcount_q);
	assign wr_idx = (wr_sum >= (PtrW+1)'(QueueDepth))
		? PtrW'(wr_sum - (PtrW+1)'(QueueDepth)) : wr_sum[PtrW-1:0];

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid && cmd_t'(in_ch.command) == CMD_ADD
				&& fcount_q < CntW'(QueueDepth))
			mem[wr_idx] <=
				{clampc(48'(in_ch.coord_z)), clampc(48'(in_ch.coord_y)),
				clampc(48'(in_ch.coord_x))};
		rd_q <= mem[fhead_q];
	end

	logic [31:0] want_full;
	logic [15:0] want, diff;
	logic signed [16:0] sdiff;
	logic [16:0] adiff;
	assign want_full = 32'(cd_zo + 34'sh8000);
	assign want = (dx_q == 0 && dy_q == 0) ? 16'h0 : want_full[31:16];
	assign diff = want - head_q;
	assign sdiff = 17'($signed(diff));
	assign adiff = sdiff[16] ? 17'(-sdiff) : 17'(sdiff);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ts_q <= in_ch.time_step;
			end
			ST_DIFF: begin
				dx_q <= (CoordBits+1)'(tx_q) - (CoordBits+1)'(px_q);
				dy_q <= (CoordBits+1)'(ty_q) - (CoordBits+1)'(py_q);
				dz_q <= (CoordBits+1)'(tz_q) - (CoordBits+1)'(pz_q);
				rot_q <= 18'((34'(turn_q) * 34'(ts_q)) >> 16);
				climb_amt_q <= 23'((39'(climb_q) * 39'(ts_q)) >> 16);
				dist_q <= 28'((32'(speed_q) * 32'(ts_q)) >> 12);
			end
			ST_SQ: begin
				big_q <= (adx >= (CoordBits+1)'(radius_q)) || (ady >= (CoordBits+1)'(radius_q))
					|| (adz >= (CoordBits+1)'(radius_q));
				sum_q <= (2*CoordBits+4)'(adx * adx) + (2*CoordBits+4)'(ady * ady)
					+ (2*CoordBits+4)'(adz * adz);
				r2_q <= 48'(radius_q) * 48'(radius_q);
			end
			ST_RSTRT: flip_q <= rflip;
			ST_MOVE: begin
				mvx_q <= 64'($signed({1'b0, dist_q})) * 64'(flip_q ? -cd_xo : cd_xo);
				mvy_q <= 64'($signed({1'b0, dist_q})) * 64'(flip_q ? -cd_yo : cd_yo);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			speed_q <= 16'd5120; radius_q <= 23'd8192;
			turn_q <= 18'd104308; climb_q <= 23'd32768;
			px_q <= '0; py_q <= '0; pz_q <= '0; head_q <= '0;
			tx_q <= '0; ty_q <= '0; tz_q <= '0;
			fhead_q <= '0; fcount_q <= '0;
			steer_off_q <= 1'b0; route_q <= 1'b0; land_q <= '0;
			rej_q <= 1'b0; reached_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_SPEED: speed_q <= cfg_data[15:0];
					REG_RADIUS: radius_q <= cfg_data;
					REG_TURN: turn_q <= cfg_data[17:0];
					REG_CLIMB: climb_q <= cfg_data;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					rej_q <= 1'b0;
					unique case (cmd_t'(in_ch.command))
						CMD_TICK: state_q <= ST_LOAD;
						CMD_ADD: begin
							if (fcount_q >= CntW'(QueueDepth)) rej_q <= 1'b1;
							else fcount_q <= fcount_q + 1'b1;
							state_q <= ST_OUT;
						end
						CMD_CLEAR: begin
							fhead_q <= '0; fcount_q <= '0; state_q <= ST_OUT;
						end
						CMD_POSE: begin
							px_q <= clampc(48'(in_ch.coord_x));
							py_q <= clampc(48'(in_ch.coord_y));
							pz_q <= clampc(48'(in_ch.coord_z));
							head_q <= in_ch.heading_in;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_LOAD: begin
					if (fcount_q != 0) begin
						tx_q <= rd_q[CoordBits-1:0];
						ty_q <= rd_q[2*CoordBits-1:CoordBits];
						tz_q <= rd_q[3*CoordBits-1:2*CoordBits];
					end
					state_q <= ST_DIFF;
				end
				ST_DIFF: state_q <= ST_SQ;
				ST_SQ: state_q <= ST_REACH;
				ST_REACH: begin
					if (steer_off_q) state_q <= ST_RSTRT;
					else if (!big_q && 48'(sum_q) < r2_q) begin
						if (fcount_q != 0) begin
							fhead_q <= (fhead_q == PtrW'(QueueDepth - 1)) ? '0
								: fhead_q + 1'b1;
						end
						if (fcount_q <= 1) begin
							steer_off_q <= 1'b1; route_q <= 1'b1;
							if (land_q != 16'hFFFF) land_q <= land_q + 1'b1;
						end
						if (fcount_q != 0) fcount_q <= fcount_q - 1'b1;
						state_q <= ST_RSTRT;
					end else state_q <= ST_VSTRT;
				end
				ST_VSTRT: state_q <= ST_VWAIT;
				ST_VWAIT: if (cd_done) state_q <= ST_STEER;
				ST_STEER: begin
					if ({1'b0, adiff} < rot_q) head_q <= want;
					else if (!sdiff[16] && sdiff != 0) head_q <= head_q + 16'(rot_q);
					else head_q <= head_q - 16'(rot_q);
					if ({1'b0, adz} < (CoordBits+2)'(climb_amt_q)) pz_q <= tz_q;
					else if (!dz_q[CoordBits] && dz_q != 0)
						pz_q <= clampc(48'(pz_q) + 48'(climb_amt_q));
					else pz_q <= clampc(48'(pz_q) - 48'(climb_amt_q));
					state_q <= ST_RSTRT;
				end
				ST_RSTRT: state_q <= ST_RWAIT;
				ST_RWAIT: if (cd_done) state_q <= ST_MOVE;
				ST_MOVE: begin
					reached_q <= 1'b1;
					if (reached_q) begin
						reached_q <= 1'b0;
						px_q <= clampc(48'(px_q) + 48'(mvx_q >>> 30));
						py_q <= clampc(48'(py_q) + 48'(mvy_q >>> 30));
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (out_ch.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ tb/sv/tb_waypoint_guidance_step.sv @@
// Self-checking testbench for waypoint_guidance_step: drives command words, predicts
// every result word with its own fixed-point model and compares field by field.
// Depends on wgs_pkg, wgs_if and the RTL of waypoint_guidance_step.
`default_nettype none
module tb_waypoint_guidance_step;
	import wgs_pkg::*;

	localparam longint CoordHi = (64'sd1 <<< 23) - 1;
	localparam longint CoordLo = -(64'sd1 <<< 23);
	localparam int CycleLimit = 1500000;

	typedef struct {
		cmd_t command;
		logic [15:0] time_step;
		logic signed [23:0] coord_x;
		logic signed [23:0] coord_y;
		logic signed [23:0] coord_z;
		logic [15:0] heading_in;
	} cmd_word_t;

	typedef struct {
		logic [23:0] pos_x;
		logic [23:0] pos_y;
		logic [23:0] pos_z;
		logic [15:0] heading_out;
		logic [4:0] waypoints_left;
		logic route_done;
		logic [15:0] landing_count;
		logic push_rejected;
	} result_word_t;

	class guidance_scoreboard;
		longint speed, radius, turn, climb;
		longint px, py, pz, tx, ty, tz;
		logic [15:0] hdg;
		longint qx[16], qy[16], qz[16];
		int head, count;
		bit steer_off, route_flag;
		int landings;
		result_word_t expected_q[$];
		longint angles[16] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
			64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53,
			64'h00145F2F, 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3,
			64'h0000A2FA, 64'h0000517D};

		function new();
			speed = 5120; radius = 8192; turn = 104308; climb = 32768;
			px = 0; py = 0; pz = 0; tx = 0; ty = 0; tz = 0; hdg = 0;
			head = 0; count = 0; steer_off = 0; route_flag = 0; landings = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [22:0] v);
			case (idx)
				REG_SPEED: speed = v[15:0];
				REG_RADIUS: radius = v;
				REG_TURN: turn = v[17:0];
				default: climb = v;
			endcase
		endfunction

		function longint clamp(longint v);
			return v > CoordHi ? CoordHi : (v < CoordLo ? CoordLo : v);
		endfunction

		function longint mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		function logic [15:0] bearing(longint x, longint y);
			longint acc, nx, ny, r;
			acc = 0;
			if (x == 0 && y == 0) return 16'h0;
			if (x < 0) begin
				x = -x; y = -y; acc = 64'h80000000;
			end
			for (int i = 0; i < 16; i++) begin
				if (y > 0) begin
					nx = x + (y >>> i); ny = y - (x >>> i); acc += angles[i];
				end else begin
					nx = x - (y >>> i); ny = y + (x >>> i); acc -= angles[i];
				end
				x = nx; y = ny;
			end
			r = (acc + 32768) >>> 16;
			return r[15:0];
		endfunction

		function void cos_sin(logic [15:0] h, output longint c, output longint s);
			logic [31:0] a, d;
			bit flip;
			longint z, x, y, nx, ny;
			a = {h, 16'h0};
			d = a - 32'h40000000;
			flip = d < 32'h80000000;
			if (flip) a = a - 32'h80000000;
			z = longint'($signed(a));
			x = 652032874; y = 0;
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i); ny = y + (x >>> i); z -= angles[i];
				end else begin
					nx = x + (y >>> i); ny = y - (x >>> i); z += angles[i];
				end
				x = nx; y = ny;
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function void tick(longint ts);
			longint dx, dy, dz, rot, clb, diff, travel, c, s, tmp;
			logic [15:0] want, d16;
			bit reach;
			if (count > 0) begin
				tx = qx[head]; ty = qy[head]; tz = qz[head];
			end
			dx = tx - px; dy = ty - py; dz = tz - pz;
			if (!steer_off) begin
				reach = mag(dx) < radius && mag(dy) < radius && mag(dz) < radius &&
					dx * dx + dy * dy + dz * dz < radius * radius;
				if (reach) begin
					if (count > 0) begin
						head = (head + 1) % 16;
						count--;
					end
					if (count == 0) begin
						steer_off = 1;
						route_flag = 1;
						if (landings < 65535) landings++;
					end
				end else begin
					want = bearing(dx, dy);
					d16 = want - hdg;
					diff = longint'($signed(d16));
					rot = (turn * ts) >> 16;
					clb = (climb * ts) >> 16;
					if (mag(diff) < rot) hdg = want;
					else begin
						tmp = longint'(hdg) + (diff > 0 ? rot : -rot);
						hdg = tmp[15:0];
					end
					if (mag(dz) < clb) pz = tz;
					else pz = clamp(pz + (dz > 0 ? clb : -clb));
				end
			end
			travel = (speed * ts) >> 12;
			cos_sin(hdg, c, s);
			px = clamp(px + ((travel * c) >>> 30));
			py = clamp(py + ((travel * s) >>> 30));
		endfunction

		function void note_word(cmd_word_t w);
			result_word_t r;
			bit rej;
			int idx;
			rej = 0;
			case (w.command)
				CMD_TICK: tick(longint'(w.time_step));
				CMD_ADD: begin
					if (count >= 16) rej = 1;
					else begin
						idx = (head + count) % 16;
						qx[idx] = w.coord_x; qy[idx] = w.coord_y; qz[idx] = w.coord_z;
						count++;
					end
				end
				CMD_CLEAR: begin
					head = 0; count = 0;
				end
				default: begin
					px = w.coord_x; py = w.coord_y; pz = w.coord_z; hdg = w.heading_in;
				end
			endcase
			r.pos_x = px[23:0]; r.pos_y = py[23:0]; r.pos_z = pz[23:0];
			r.heading_out = hdg; r.waypoints_left = count[4:0];
			r.route_done = route_flag; r.landing_count = landings[15:0];
			r.push_rejected = rej;
			expected_q.insert(expected_q.size(), r);
		endfunction

		function bit check_word(result_word_t got, output string msg);
			result_word_t e;
			msg = "";
			if (expected_q.size() == 0) begin
				msg = "result word with nothing expected";
				return 0;
			end
			e = expected_q.pop_front();
			if (got.pos_x !== e.pos_x) msg = {msg, $sformatf(" pos_x %h/%h", got.pos_x, e.pos_x)};
			if (got.pos_y !== e.pos_y) msg = {msg, $sformatf(" pos_y %h/%h", got.pos_y, e.pos_y)};
			if (got.pos_z !== e.pos_z) msg = {msg, $sformatf(" pos_z %h/%h", got.pos_z, e.pos_z)};
			if (got.heading_out !== e.heading_out)
				msg = {msg, $sformatf(" heading %h/%h", got.heading_out, e.heading_out)};
			if (got.waypoints_left !== e.waypoints_left)
				msg = {msg, $sformatf(" left %0d/%0d", got.waypoints_left, e.waypoints_left)};
			if (got.route_done !== e.route_done)
				msg = {msg, $sformatf(" done %b/%b", got.route_done, e.route_done)};
			if (got.landing_count !== e.landing_count)
				msg = {msg, $sformatf(" landings %0d/%0d", got.landing_count, e.landing_count)};
			if (got.push_rejected !== e.push_rejected)
				msg = {msg, $sformatf(" rejected %b/%b", got.push_rejected, e.push_rejected)};
			if (msg != "") begin
				msg = {"mismatch (got/expected):", msg};
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [22:0] cfg_data;
	int errors;
	int cycles;
	int stall_left;
	bit quiet;
	guidance_scoreboard sb;

	wgs_in_if in_ch();
	wgs_out_if out_ch();

	waypoint_guidance_step u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	task automatic report(input string msg);
		errors++;
		$display("ERROR at cycle %0d: %s", cycles, msg);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(input cmd_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_ch.command = w.command;
		in_ch.time_step = w.time_step;
		in_ch.coord_x = w.coord_x;
		in_ch.coord_y = w.coord_y;
		in_ch.coord_z = w.coord_z;
		in_ch.heading_in = w.heading_in;
		in_ch.valid = 1;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_word(w);
		@(negedge clk);
		in_ch.valid = 0;
	endtask

	task automatic issue(input cmd_t c, input logic [15:0] ts, input longint x, input longint y,
		input longint z, input logic [15:0] h);
		cmd_word_t w;
		w.command = c;
		w.time_step = ts;
		w.coord_x = x[23:0];
		w.coord_y = y[23:0];
		w.coord_z = z[23:0];
		w.heading_in = h;
		send_word(w);
	endtask

	function automatic longint rnd_coord();
		logic [23:0] v;
		v = 24'($urandom);
		return longint'($signed(v));
	endfunction

	function automatic longint near(longint base);
		longint span;
		span = sb.radius < 64 ? 64 : (sb.radius > 32'h100000 ? 32'h100000 : sb.radius);
		return sb.clamp(base + longint'($urandom_range(0, 32'(2 * span))) - span);
	endfunction

	task automatic drain();
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [22:0] v);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 0;
		sb.set_reg(idx, v);
	endtask

	task automatic random_phase(input int items);
		logic [15:0] ts;
		int r;
		for (int n = 0; n < items; n++) begin
			if (n % 100 == 0) quiet = $urandom_range(0, 3) == 0;
			r = $urandom_range(0, 99);
			ts = $urandom_range(0, 9) < 7 ? 16'($urandom) : 16'($urandom_range(0, 1024));
			if (sb.count <= 2 || (r < 18 && sb.count < 16) || r >= 97) begin
				if ($urandom_range(0, 1)) issue(CMD_ADD, 16'($urandom), near(sb.px),
					near(sb.py), near(sb.pz), 16'($urandom));
				else issue(CMD_ADD, 16'($urandom), rnd_coord(), rnd_coord(), rnd_coord(),
					16'($urandom));
			end else if (r < 72) issue(CMD_TICK, ts, rnd_coord(), rnd_coord(), rnd_coord(),
				16'($urandom));
			else if (r < 76) begin
				issue(CMD_CLEAR, ts, rnd_coord(), rnd_coord(), rnd_coord(), 16'($urandom));
				repeat (3) issue(CMD_ADD, ts, rnd_coord(), rnd_coord(), rnd_coord(),
					16'($urandom));
			end else if (r < 86) issue(CMD_POSE, ts, rnd_coord(), rnd_coord(), rnd_coord(),
				16'($urandom));
			else if (r < 94) begin
				issue(CMD_POSE, ts, near(sb.qx[sb.head]), near(sb.qy[sb.head]),
					near(sb.qz[sb.head]), 16'($urandom));
			end else issue(CMD_ADD, ts, CoordHi, CoordLo, $urandom_range(0, 1) ? CoordHi : CoordLo,
				16'($urandom));
		end
		quiet = 0;
	endtask

	initial begin
		sb = new();
		errors = 0;
		quiet = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_SPEED;
		cfg_data = '0;
		in_ch.valid = 0;
		in_ch.command = CMD_TICK;
		in_ch.time_step = '0;
		in_ch.coord_x = '0;
		in_ch.coord_y = '0;
		in_ch.coord_z = '0;
		in_ch.heading_in = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (3) @(negedge clk);

		issue(CMD_POSE, 0, CoordLo, CoordLo, CoordLo, 16'h0000);
		for (int i = 0; i < 17; i++)
			issue(CMD_ADD, 16'hFFFF, rnd_coord(), rnd_coord(), rnd_coord(), 16'hFFFF);
		issue(CMD_TICK, 16'h0000, 0, 0, 0, 0);
		issue(CMD_TICK, 16'hFFFF, CoordHi, CoordHi, CoordHi, 16'hFFFF);
		issue(CMD_CLEAR, 16'hFFFF, CoordLo, CoordHi, CoordLo, 16'h5555);
		issue(CMD_POSE, 0, 0, 0, 0, 16'h8000);
		issue(CMD_ADD, 0, 0, 0, 0, 0);
		issue(CMD_ADD, 0, 0, 0, 24'sh300000, 0);
		issue(CMD_ADD, 0, 24'sh400000, 0, 0, 0);
		issue(CMD_ADD, 0, 24'sh400000, 24'sh400000, 0, 0);
		issue(CMD_TICK, 16'h0000, 0, 0, 0, 0);
		issue(CMD_TICK, 16'h2000, 0, 0, 0, 0);
		issue(CMD_POSE, 0, CoordHi, CoordHi, CoordHi, 16'hFFFF);
		issue(CMD_TICK, 16'hFFFF, 0, 0, 0, 0);
		random_phase(250);
		drain();

		write_reg(REG_SPEED, 23'($urandom));
		write_reg(REG_RADIUS, 23'($urandom_range(0, 23'h20000)));
		write_reg(REG_TURN, 23'($urandom));
		write_reg(REG_CLIMB, 23'($urandom_range(0, 23'h100000)));
		random_phase(280);
		drain();
		write_reg(REG_SPEED, 0);
		write_reg(REG_RADIUS, 0);
		write_reg(REG_TURN, 0);
		write_reg(REG_CLIMB, 0);
		random_phase(200);
		drain();
		write_reg(REG_SPEED, 23'hFFFF);
		write_reg(REG_RADIUS, 23'h7FFFFF);
		write_reg(REG_TURN, 23'h3FFFF);
		write_reg(REG_CLIMB, 23'h7FFFFF);
		random_phase(250);
		drain();
		write_reg(REG_SPEED, 23'($urandom_range(0, 23'h4000)));
		write_reg(REG_RADIUS, 23'($urandom_range(0, 23'h8000)));
		write_reg(REG_TURN, 23'($urandom_range(23'h10000, 23'h3FFFF)));
		write_reg(REG_CLIMB, 23'($urandom));
		random_phase(300);
		drain();
		write_reg(REG_SPEED, 5120);
		write_reg(REG_RADIUS, 8192);
		write_reg(REG_TURN, 104308);
		write_reg(REG_CLIMB, 32768);
		random_phase(300);

		// Empty the queue and sit on the last target so that the route completes.
		issue(CMD_CLEAR, 0, 0, 0, 0, 0);
		issue(CMD_POSE, 0, sb.tx, sb.ty, sb.tz, 16'($urandom));
		issue(CMD_TICK, 16'($urandom), 0, 0, 0, 0);
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(0, 2) == 0)
				issue(CMD_ADD, 16'($urandom), rnd_coord(), rnd_coord(), rnd_coord(),
					16'($urandom));
			else issue(CMD_TICK, 16'($urandom), rnd_coord(), rnd_coord(), rnd_coord(),
				16'($urandom));
		end
		in_ch.valid = 0;
		drain();
		if (sb.expected_q.size() > 0)
			report($sformatf("%0d result words never arrived", sb.expected_q.size()));
		if (errors == 0) $display("tb_waypoint_guidance_step: PASS");
		else $display("tb_waypoint_guidance_step: FAIL");
		$finish;
	end

	initial begin
		out_ch.ready = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ch.ready = 0;
				stall_left--;
			end else begin
				out_ch.ready = 1;
				if (!quiet && $urandom_range(0, 9) < 3) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		string msg;
		result_word_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.pos_x = out_ch.pos_x;
			got.pos_y = out_ch.pos_y;
			got.pos_z = out_ch.pos_z;
			got.heading_out = out_ch.heading_out;
			got.waypoints_left = out_ch.waypoints_left;
			got.route_done = out_ch.route_done;
			got.landing_count = out_ch.landing_count;
			got.push_rejected = out_ch.push_rejected;
			if (!sb.check_word(got, msg)) report(msg);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb_waypoint_guidance_step: FAIL");
			$finish;
		end
	end

	initial cycles = 0;
endmodule
`default_nettype wire
